/* src/s2u_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2u_pkg
// Shared types, constants and helpers for the sensor string to UTF-8 core.
// ----------------------------------------------------------------------------
package s2u_pkg;

    localparam int FMT_W = 2;

    typedef enum logic [FMT_W-1:0] {
        FMT_UNICODE32 = 2'd0,
        FMT_BCD_PLUS  = 2'd1,
        FMT_ASCII6    = 2'd2,
        FMT_LATIN1    = 2'd3
    } s2u_fmt_t;

    localparam logic [31:0] CP_MAX_1B = 32'h0000_007F;
    localparam logic [31:0] CP_MAX_2B = 32'h0000_07FF;
    localparam logic [31:0] CP_MAX_3B = 32'h0000_FFFF;
    localparam logic [31:0] CP_MAX    = 32'h0010_FFFF;

    localparam logic [7:0] ASCII6_BASE = 8'h20;
    localparam logic [7:0] LEAD_2B     = 8'hC0;
    localparam logic [7:0] LEAD_3B     = 8'hE0;
    localparam logic [7:0] LEAD_4B     = 8'hF0;
    localparam logic [7:0] CONT_BYTE   = 8'h80;

    // bcd plus character table, entry 15 first
    localparam logic [15:0][7:0] BCD_CHARS = {
        8'h5F, 8'h2C, 8'h3A, 8'h2E, 8'h2D, 8'h20, 8'h39, 8'h38,
        8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } s2u_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       end_of_string;
    } s2u_out_t;

    typedef struct packed {
        logic [23:0] group_bytes;
        logic [1:0]  group_count;
        logic        at_first_byte;
        logic        output_stopped;
    } s2u_state_t;

    // up to four output bytes produced by one input byte
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [2:0]      count;
        logic            bare;
        logic            eos;
    } s2u_bundle_t;

    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [2:0]      count;
    } s2u_enc_t;

    function automatic s2u_enc_t utf8_encode(input logic [31:0] cp);
        s2u_enc_t e;
        e.chars = '0;
        if (cp <= CP_MAX_1B) begin
            e.chars[0] = cp[7:0];
            e.count    = 3'd1;
        end else if (cp <= CP_MAX_2B) begin
            e.chars[0] = LEAD_2B | {3'b000, cp[10:6]};
            e.chars[1] = CONT_BYTE | {2'b00, cp[5:0]};
            e.count    = 3'd2;
        end else if (cp <= CP_MAX_3B) begin
            e.chars[0] = LEAD_3B | {4'b0000, cp[15:12]};
            e.chars[1] = CONT_BYTE | {2'b00, cp[11:6]};
            e.chars[2] = CONT_BYTE | {2'b00, cp[5:0]};
            e.count    = 3'd3;
        end else if (cp <= CP_MAX) begin
            e.chars[0] = LEAD_4B | {5'b00000, cp[20:18]};
            e.chars[1] = CONT_BYTE | {2'b00, cp[17:12]};
            e.chars[2] = CONT_BYTE | {2'b00, cp[11:6]};
            e.chars[3] = CONT_BYTE | {2'b00, cp[5:0]};
            e.count    = 3'd4;
        end else begin
            // replacement character
            e.chars[0] = 8'hEF;
            e.chars[1] = 8'hBF;
            e.chars[2] = 8'hBD;
            e.count    = 3'd3;
        end
        return e;
    endfunction

    function automatic logic [7:0] ascii6_char(input logic [5:0] code);
        return ASCII6_BASE + {2'b00, code};
    endfunction

endpackage

/* src/s2u_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2u_decode
// Turns one raw string byte plus the running group state into the bundle
// of UTF-8 bytes it produces and the next group state.
// ----------------------------------------------------------------------------
module s2u_decode (
    input  s2u_pkg::s2u_in_t     item,
    input  s2u_pkg::s2u_fmt_t    fmt,
    input  s2u_pkg::s2u_state_t  st,
    output s2u_pkg::s2u_bundle_t bundle,
    output s2u_pkg::s2u_state_t  st_next
);
    import s2u_pkg::*;

    logic [7:0]  b;
    logic        empty_str;
    logic [31:0] cp;
    logic [23:0] gb_merged;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    s2u_enc_t    enc;

    assign b         = item.in_byte;
    assign empty_str = st.at_first_byte && item.last_byte && (b == 8'h00);
    assign gb_merged = st.group_bytes | ({16'h0000, b} << {st.group_count, 3'b000});
    assign cp        = {b, st.group_bytes};

    // six-bit group sources: either a complete group or a padded short one
    always_comb begin
        if (st.group_count >= 2'd2) begin
            b0 = st.group_bytes[7:0];
            b1 = st.group_bytes[15:8];
            b2 = b;
        end else begin
            b0 = gb_merged[7:0];
            b1 = gb_merged[15:8];
            b2 = 8'h00;
        end
    end

    assign enc = utf8_encode(fmt == FMT_LATIN1 ? {24'h0, b} : cp);

    always_comb begin
        bundle        = '0;
        st_next       = st;
        st_next.at_first_byte = 1'b0;

        if (!empty_str) begin
            unique case (fmt)
                FMT_UNICODE32: begin
                    if (st.group_count == 2'd3) begin
                        st_next.group_bytes = '0;
                        st_next.group_count = '0;
                        if (!st.output_stopped) begin
                            if (cp == 32'h0) begin
                                st_next.output_stopped = 1'b1;
                            end else begin
                                bundle.chars = enc.chars;
                                bundle.count = enc.count;
                            end
                        end
                    end else begin
                        st_next.group_bytes = gb_merged;
                        st_next.group_count = st.group_count + 2'd1;
                    end
                end
                FMT_BCD_PLUS: begin
                    if (!st.output_stopped) begin
                        bundle.chars[0] = BCD_CHARS[b[7:4]];
                        bundle.chars[1] = BCD_CHARS[b[3:0]];
                        bundle.count    = 3'd2;
                    end
                end
                FMT_ASCII6: begin
                    if (st.group_count >= 2'd2) begin
                        st_next.group_bytes = '0;
                        st_next.group_count = '0;
                    end else begin
                        st_next.group_bytes = gb_merged;
                        st_next.group_count = st.group_count + 2'd1;
                    end
                    // six-bit characters are never zero and always one byte
                    if (!st.output_stopped &&
                        (st.group_count >= 2'd2 || item.last_byte)) begin
                        bundle.chars[0] = ascii6_char(b0[5:0]);
                        bundle.chars[1] = ascii6_char({b1[3:0], b0[7:6]});
                        bundle.chars[2] = ascii6_char({b2[1:0], b1[7:4]});
                        bundle.chars[3] = ascii6_char(b2[7:2]);
                        bundle.count    = 3'd4;
                    end
                end
                FMT_LATIN1: begin
                    if (!st.output_stopped) begin
                        if (b == 8'h00) begin
                            st_next.output_stopped = 1'b1;
                        end else begin
                            bundle.chars = enc.chars;
                            bundle.count = enc.count;
                        end
                    end
                end
                default: begin
                    bundle.count = '0;
                end
            endcase
        end

        if (item.last_byte) begin
            bundle.eos = 1'b1;
            if (bundle.count == 3'd0) begin
                bundle.chars = '0;
                bundle.count = 3'd1;
                bundle.bare  = 1'b1;
            end
            st_next.group_bytes    = '0;
            st_next.group_count    = '0;
            st_next.at_first_byte  = 1'b1;
            st_next.output_stopped = 1'b0;
        end
    end

endmodule

/* src/sensor_string_to_utf8_core.sv */
`timescale 1ns / 1ps
// path: a request is held in the input register, then its bytes are loaded
// into the output drain register; the drain emits one output byte per cycle
// while m_ready is high, and the next bundle loads as its last byte is taken
// reset: synchronous active low, clears handshake, group state and format
// (format returns to 32-bit unicode)
// ----------------------------------------------------------------------------
// sensor_string_to_utf8_core
// Decodes sensor record string bytes in one of four formats into UTF-8.
// ----------------------------------------------------------------------------
module sensor_string_to_utf8_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  s2u_pkg::s2u_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output s2u_pkg::s2u_out_t  m_data,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data
);
    import s2u_pkg::*;

    s2u_fmt_t    fmt_reg;
    logic        in_vld_reg;
    s2u_in_t     in_data_reg;
    s2u_state_t  state_reg;
    s2u_state_t  state_next;
    s2u_bundle_t bundle;

    logic [3:0][7:0] drain_chars_reg;
    logic [1:0]      drain_idx_reg;
    logic [1:0]      drain_last_reg;
    logic            drain_bare_reg;
    logic            drain_eos_reg;
    logic            drain_vld_reg;

    logic drain_free;
    logic consume;
    logic drain_load;
    logic out_take;

    s2u_decode u_decode (
        .item    (in_data_reg),
        .fmt     (fmt_reg),
        .st      (state_reg),
        .bundle  (bundle),
        .st_next (state_next)
    );

    assign out_take   = m_valid && m_ready;
    assign drain_free = !drain_vld_reg || (out_take && drain_idx_reg == drain_last_reg);
    // requests that produce nothing pass without touching the drain
    assign consume    = in_vld_reg && (bundle.count == 3'd0 || drain_free);
    assign drain_load = consume && bundle.count != 3'd0;
    assign s_ready    = !in_vld_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_UNICODE32;
        end else if (cfg_wr_en) begin
            fmt_reg <= s2u_fmt_t'(cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.group_bytes    <= '0;
            state_reg.group_count    <= '0;
            state_reg.at_first_byte  <= 1'b1;
            state_reg.output_stopped <= 1'b0;
        end else if (consume) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drain_vld_reg <= 1'b0;
            drain_idx_reg <= '0;
        end else if (drain_load) begin
            drain_vld_reg <= 1'b1;
            drain_idx_reg <= '0;
        end else if (out_take) begin
            if (drain_idx_reg == drain_last_reg) begin
                drain_vld_reg <= 1'b0;
            end else begin
                drain_idx_reg <= drain_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (drain_load) begin
            drain_chars_reg <= bundle.chars;
            drain_last_reg  <= 2'(bundle.count - 3'd1);
            drain_bare_reg  <= bundle.bare;
            drain_eos_reg   <= bundle.eos;
        end
    end

    assign m_valid              = drain_vld_reg;
    assign m_data.out_char      = drain_chars_reg[drain_idx_reg];
    assign m_data.char_valid    = !drain_bare_reg;
    assign m_data.end_of_string = drain_eos_reg && (drain_idx_reg == drain_last_reg);

endmodule
